/* rtl/acs_pkg.sv */
// ----------------------------------------------------------------------------
// ANSI escape stripper package
// Shared types and character constants for the escape-sequence stripper.
// ----------------------------------------------------------------------------
package acs_pkg;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_CSI      = 8'h9B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;

   // Ranges that end or form an escape sequence.
   localparam logic [7:0] FINAL_LO = 8'd64;
   localparam logic [7:0] FINAL_HI = 8'd126;
   localparam logic [7:0] TWO_LO   = 8'd64;
   localparam logic [7:0] TWO_HI   = 8'd95;

   // Result queue geometry.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_NORMAL  = 2'd0,
      PH_TWO     = 2'd1,
      PH_BRACKET = 2'd2,
      PH_INSIDE  = 2'd3
   } acs_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       line_end;
   } acs_result_type;

   // Up to two results produced by one input transfer, in delivery order.
   typedef struct packed {
      logic           first_valid;
      logic           second_valid;
      acs_result_type first;
      acs_result_type second;
   } acs_push_type;

endpackage

/* rtl/acs_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one raw byte and its end-of-line flag.
// ----------------------------------------------------------------------------
interface acs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       line_last;

   modport source (output valid, output in_byte, output line_last, input ready);
   modport sink   (input valid, input in_byte, input line_last, output ready);
endinterface

/* rtl/acs_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one kept byte and the line-end mark.
// ----------------------------------------------------------------------------
interface acs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       line_end;

   modport source (output valid, output out_byte, output byte_valid, output line_end,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input line_end,
                   output ready);
endinterface

/* rtl/acs_parser.sv */
// ----------------------------------------------------------------------------
// Escape parser
// Holds one byte back, decides it against the next byte and produces the
// results of each accepted input transfer.
// ----------------------------------------------------------------------------
module acs_parser
   import acs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   in_byte,
   input  logic         line_last,
   output acs_push_type push
);

   acs_phase_type phase_ff, phase_in;
   logic          suppress_ff, suppress_in;
   logic [7:0]    held_ff, held_in;
   logic          held_valid_ff, held_valid_in;

   acs_phase_type phase_d;
   logic          suppress_d;
   logic          keep_held;
   logic          keep_last;

   // Decide the held byte using the incoming byte as lookahead.
   always_comb begin
      phase_d    = phase_ff;
      suppress_d = suppress_ff;
      if (held_valid_ff) begin
         unique case (phase_ff)
            PH_TWO: begin
               phase_d = PH_NORMAL;
            end
            PH_BRACKET: begin
               phase_d = PH_INSIDE;
            end
            PH_INSIDE: begin
               if (held_ff >= FINAL_LO && held_ff <= FINAL_HI) begin
                  phase_d = PH_NORMAL;
               end
            end
            PH_NORMAL: begin
               phase_d    = PH_NORMAL;
               suppress_d = (held_ff == CH_CSI);
               if (held_ff == CH_ESC) begin
                  if (in_byte == CH_LBRACKET) begin
                     phase_d    = PH_BRACKET;
                     suppress_d = 1'b1;
                  end else if (in_byte >= TWO_LO && in_byte <= TWO_HI) begin
                     phase_d    = PH_TWO;
                     suppress_d = 1'b1;
                  end
               end
            end
            default: begin
               phase_d = PH_NORMAL;
            end
         endcase
      end
   end

   assign keep_held = held_valid_ff && !suppress_d;
   assign keep_last = (phase_d == PH_NORMAL);

   always_comb begin
      acs_result_type held_res;
      acs_result_type last_res;

      held_res.out_byte   = held_ff;
      held_res.byte_valid = 1'b1;
      held_res.line_end   = 1'b0;

      last_res.out_byte   = keep_last ? in_byte : 8'd0;
      last_res.byte_valid = keep_last;
      last_res.line_end   = 1'b1;

      // The first slot carries whichever result comes first; the second
      // slot is used only when both are produced.
      push.first_valid  = accept && (keep_held || line_last);
      push.second_valid = accept && keep_held && line_last;
      push.first        = keep_held ? held_res : last_res;
      push.second       = last_res;
   end

   always_comb begin
      phase_in      = phase_ff;
      suppress_in   = suppress_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (line_last) begin
            phase_in      = PH_NORMAL;
            suppress_in   = 1'b0;
            held_in       = 8'd0;
            held_valid_in = 1'b0;
         end else begin
            phase_in      = phase_d;
            suppress_in   = suppress_d;
            held_in       = in_byte;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NORMAL;
         suppress_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         suppress_ff   <= suppress_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

/* rtl/acs_rsp_queue.sv */
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and delivers
// one per response transfer.
// ----------------------------------------------------------------------------
module acs_rsp_queue
   import acs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  acs_push_type      push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output acs_result_type    out_data
);

   acs_result_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] push_n;
   logic              pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Accept only while two slots are free, whatever the item turns out to need.
   assign room = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   assign push_n = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + push_n - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         slot_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

endmodule

/* rtl/ansi_csi_stripper_core.sv */
// ----------------------------------------------------------------------------
// ANSI escape sequence stripper
// Removes escape and control sequences from a byte stream, one line at a time.
// ----------------------------------------------------------------------------
// Usage: bytes of a line enter on req_chan, the final byte with line_last set.
// Kept bytes leave on rsp_chan; the final response of each line has line_end
// set and carries the final byte if it was kept, or byte_valid low otherwise.
// One byte is held back as lookahead, so a byte's response appears when the
// next byte of the line is transferred. Responses are written into a
// four-entry register queue in the same cycle as the request transfer and are
// read out to rsp_chan from those registers in order.
// Throughput: one request per cycle while the queue has two free entries; a
// final byte can produce two responses, which drain at one per cycle, so the
// response port sets the sustained rate of one response per cycle.
// Reset (synchronous, active high) clears the parser state and empties the
// queue. When the receiver stalls, responses collect in the queue and
// req_chan.ready drops once fewer than two entries remain free.
// ----------------------------------------------------------------------------
module ansi_csi_stripper_core
   import acs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   acs_req_if.sink   req_chan,
   acs_rsp_if.source rsp_chan
);

   acs_push_type   push;
   acs_result_type rsp_data;
   logic           room;
   logic           accept;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   acs_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_chan.in_byte),
      .line_last (req_chan.line_last),
      .push      (push)
   );

   acs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.out_byte   = rsp_data.out_byte;
   assign rsp_chan.byte_valid = rsp_data.byte_valid;
   assign rsp_chan.line_end   = rsp_data.line_end;

endmodule

/* rtl/acs_checker.sv */
// ----------------------------------------------------------------------------
// Stripper port checker
// Checks the port behavior of the stripper over time.
// ----------------------------------------------------------------------------
module acs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_line_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_line_end
);

   // Reset empties the response queue.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_line_end))
      else $error("stalled response changed");

   // A dropped byte never shows stale data.
   a_empty_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("dropped byte carries data");

   // Every line end yields at least one pending response.
   a_line_end_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_line_last |=> rsp_valid)
      else $error("no response after final byte");

   // Requests stall only while responses are pending.
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with nothing pending");

endmodule

bind ansi_csi_stripper_core acs_checker u_acs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_line_last  (req_chan.line_last),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_byte_valid (rsp_chan.byte_valid),
   .rsp_line_end   (rsp_chan.line_end)
);
